### rtl/irfd_pkg.sv
// ----------------------------------------------------------------------------
// irfd_pkg
// shared types, codes and reset constants of the ir remote frame decoder
// ----------------------------------------------------------------------------
package irfd_pkg;

    localparam int INTERVAL_W  = 16;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int FRAME_BITS  = 32;
    localparam int BIT_CNT_W   = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_DATA_W-1:0] LEADER_MIN_RST = 16'd7500;
    localparam logic [CFG_DATA_W-1:0] SPACE_MIN_RST  = 16'd3000;
    localparam logic [CFG_DATA_W-1:0] ONE_MIN_RST    = 16'd1200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER_MIN = 2'd0,
        CFG_SPACE_MIN  = 2'd1,
        CFG_ONE_MIN    = 2'd2
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_REPEAT = 2'd2,
        ST_BADCHK = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_SKIP_LEAD   = 3'd0,
        PH_LEADER      = 3'd1,
        PH_SPACE       = 3'd2,
        PH_BIT_SKIP    = 3'd3,
        PH_BIT_READ    = 3'd4,
        PH_STOP_REPEAT = 3'd5,
        PH_STOP_FRAME  = 3'd6
    } t_phase;

    // classification of one interval against the thresholds
    typedef struct packed {
        logic lt_leader;
        logic lt_space;
        logic ge_one;
    } t_class;

endpackage

### rtl/irfd_if.sv
// ----------------------------------------------------------------------------
// irfd_if
// valid/ready channels carrying interval items and decoded frame items
// ----------------------------------------------------------------------------
interface irfd_in_if;
    import irfd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [INTERVAL_W-1:0] interval_us;

    modport source (output valid, output interval_us, input ready);
    modport sink   (input valid, input interval_us, output ready);
endinterface

interface irfd_out_if;
    import irfd_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   address;
    logic [BYTE_W-1:0]   command;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output address, output command, output status,
                    input ready);
    modport sink   (input valid, input address, input command, input status,
                    output ready);
endinterface

### rtl/irfd_front.sv
// ----------------------------------------------------------------------------
// irfd_front
// holds the thresholds, accepts interval items and classifies them
// ----------------------------------------------------------------------------
module irfd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [irfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [irfd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    irfd_in_if.sink                          i_in,
    input  logic                             i_q_full,
    output logic                             o_push,
    output irfd_pkg::t_class                 o_class
);
    import irfd_pkg::*;

    logic [CFG_DATA_W-1:0] r_leader_min;
    logic [CFG_DATA_W-1:0] r_space_min;
    logic [CFG_DATA_W-1:0] r_one_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_min <= LEADER_MIN_RST;
            r_space_min  <= SPACE_MIN_RST;
            r_one_min    <= ONE_MIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEADER_MIN: r_leader_min <= i_cfg_wdata;
                CFG_SPACE_MIN:  r_space_min  <= i_cfg_wdata;
                CFG_ONE_MIN:    r_one_min    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign i_in.ready        = !i_q_full;
    assign o_push            = i_in.valid && !i_q_full;
    assign o_class.lt_leader = i_in.interval_us < r_leader_min;
    assign o_class.lt_space  = i_in.interval_us < r_space_min;
    assign o_class.ge_one    = i_in.interval_us >= r_one_min;

endmodule

### rtl/irfd_queue.sv
// ----------------------------------------------------------------------------
// irfd_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module irfd_queue #(
    parameter int DEPTH = irfd_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  irfd_pkg::t_class  i_class,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output irfd_pkg::t_class  o_class
);
    import irfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_class             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_class = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("push into full queue");
    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("queue count did not grow on push");
`endif

endmodule

### rtl/irfd_back.sv
// ----------------------------------------------------------------------------
// irfd_back
// frame phase machine and registered result stage
// ----------------------------------------------------------------------------
module irfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  irfd_pkg::t_class  i_class,
    output logic              o_pop,
    irfd_out_if.source        o_out
);
    import irfd_pkg::*;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [BIT_CNT_W-1:0]  r_bit_count;
    logic [BIT_CNT_W-1:0]  n_bit_count;
    logic [FRAME_BITS-1:0] r_frame_bits;
    logic [FRAME_BITS-1:0] n_frame_bits;
    logic [BIT_CNT_W-1:0]  w_bit_inc;
    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_address;
    logic [BYTE_W-1:0]     r_command;
    t_status               r_status;
    logic                  w_emit;
    logic [BYTE_W-1:0]     w_address;
    logic [BYTE_W-1:0]     w_command;
    t_status               w_status;
    logic                  w_chk_ok;

    assign o_pop     = i_q_valid && (!r_out_valid || o_out.ready);
    assign w_bit_inc = r_bit_count + BIT_CNT_W'(1);
    assign w_chk_ok  = (r_frame_bits[7:0] == ~r_frame_bits[15:8])
                    && (r_frame_bits[23:16] == ~r_frame_bits[31:24]);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (o_pop) begin
            case (r_phase)
                PH_LEADER:      n_phase = i_class.lt_leader ? PH_SKIP_LEAD : PH_SPACE;
                PH_SPACE:       n_phase = i_class.lt_space ? PH_STOP_REPEAT : PH_BIT_SKIP;
                PH_BIT_SKIP:    n_phase = PH_BIT_READ;
                PH_BIT_READ:    n_phase = (w_bit_inc >= BIT_CNT_W'(FRAME_BITS))
                                        ? PH_STOP_FRAME : PH_BIT_SKIP;
                PH_STOP_REPEAT: n_phase = PH_SKIP_LEAD;
                PH_STOP_FRAME:  n_phase = PH_SKIP_LEAD;
                default:        n_phase = PH_LEADER;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_bit_count  = r_bit_count;
        n_frame_bits = r_frame_bits;
        w_emit       = 1'b0;
        w_address    = '0;
        w_command    = '0;
        w_status     = ST_OK;
        if (o_pop) begin
            case (r_phase)
                PH_LEADER: begin
                    if (i_class.lt_leader) begin
                        w_emit   = 1'b1;
                        w_status = ST_SHORT;
                    end
                end
                PH_SPACE: begin
                    if (!i_class.lt_space) begin
                        n_bit_count  = '0;
                        n_frame_bits = '0;
                    end
                end
                PH_BIT_READ: begin
                    if (i_class.ge_one) begin
                        n_frame_bits[r_bit_count[$clog2(FRAME_BITS)-1:0]] = 1'b1;
                    end
                    n_bit_count = w_bit_inc;
                end
                PH_STOP_REPEAT: begin
                    w_emit   = 1'b1;
                    w_status = ST_REPEAT;
                end
                PH_STOP_FRAME: begin
                    w_emit = 1'b1;
                    if (w_chk_ok) begin
                        w_address = r_frame_bits[7:0];
                        w_command = r_frame_bits[23:16];
                        w_status  = ST_OK;
                    end else begin
                        w_command = '1;
                        w_status  = ST_BADCHK;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SKIP_LEAD;
            r_bit_count  <= '0;
            r_frame_bits <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_frame_bits <= n_frame_bits;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_address <= w_address;
            r_command <= w_command;
            r_status  <= w_status;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.address = r_address;
    assign o_out.command = r_command;
    assign o_out.status  = r_status;

`ifndef SYNTHESIS
    a_bit_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= BIT_CNT_W'(FRAME_BITS))
        else $error("bit count past frame length");
    a_stop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STOP_FRAME) |-> (r_bit_count == BIT_CNT_W'(FRAME_BITS)))
        else $error("stop phase before all bits read");
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_address == '0))
        else $error("address nonzero on failed frame");
    a_emit_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_phase == PH_SKIP_LEAD && r_out_valid))
        else $error("result did not restart the frame");
`endif

endmodule

### rtl/ir_remote_frame_decoder_top.sv
// o_out is driven from a result register, loaded as a frame's last item leaves the queue
// throughput: one interval item per cycle while o_out.ready stays high
// a two-entry queue between classifier and phase machine takes two items while o_out stalls
// reset: synchronous active-low; phase, counters, queue and output valid clear,
// thresholds return to 7500, 3000 and 1200 us
// ----------------------------------------------------------------------------
// ir_remote_frame_decoder_top
// nec style infrared frame decoder: intervals in, address/command/status out
// ----------------------------------------------------------------------------
module ir_remote_frame_decoder_top #(
    parameter int QUEUE_DEPTH = irfd_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [irfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [irfd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    irfd_in_if.sink                          i_in,
    irfd_out_if.source                       o_out
);
    import irfd_pkg::*;

    logic   w_push;
    logic   w_pop;
    logic   w_q_full;
    logic   w_q_valid;
    t_class w_class_in;
    t_class w_class_out;

    irfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_class     (w_class_in)
    );

    irfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_class (w_class_in),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_class (w_class_out)
    );

    irfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_class   (w_class_out),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

### tb/ir_remote_frame_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_remote_frame_decoder_top_test
// self-checking bench for the ir frame decoder: a short table of edge
// intervals, some rows with hand-written results, then frames, repeats,
// short leaders and noise under several threshold settings, the rest scored by a decoder model
// ----------------------------------------------------------------------------
module ir_remote_frame_decoder_top_test;
    import irfd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 340;
    localparam int NUM_PHASES  = 5;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] command;
        t_status           status;
    } t_frame_result;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        logic                  typed_en;
        t_frame_result         typed;
    } t_stim_row;

    localparam t_frame_result NO_RESULT = '{8'd0, 8'd0, ST_OK};
    localparam int DIRECTED_ROWS = 18;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    irfd_in_if  in_ch ();
    irfd_out_if out_ch ();

    ir_remote_frame_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // decoder model state
    t_phase                dec_phase   = PH_SKIP_LEAD;
    logic [BIT_CNT_W-1:0]  dec_bit_cnt = '0;
    logic [FRAME_BITS-1:0] dec_bits    = '0;
    logic [CFG_DATA_W-1:0] thr_leader  = LEADER_MIN_RST;
    logic [CFG_DATA_W-1:0] thr_space   = SPACE_MIN_RST;
    logic [CFG_DATA_W-1:0] thr_one     = ONE_MIN_RST;

    t_frame_result expected_frames [$];
    logic [INTERVAL_W-1:0] seq_buf [$];
    int mismatch_count = 0;
    int items_sent = 0;
    int ready_pct = 100;
    int gap_max = 0;
    int burst_left = 0;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{16'd65535, 1'b0, NO_RESULT},
        '{16'd0,     1'b1, '{8'd0, 8'd0, ST_SHORT}},
        '{16'd0,     1'b0, NO_RESULT},
        '{16'd7499,  1'b1, '{8'd0, 8'd0, ST_SHORT}},
        '{16'd12345, 1'b0, NO_RESULT},
        '{16'd7500,  1'b0, NO_RESULT},
        '{16'd2999,  1'b0, NO_RESULT},
        '{16'd0,     1'b1, '{8'd0, 8'd0, ST_REPEAT}},
        '{16'd0,     1'b0, NO_RESULT},
        '{16'd65535, 1'b0, NO_RESULT},
        '{16'd0,     1'b0, NO_RESULT},
        '{16'd65535, 1'b1, '{8'd0, 8'd0, ST_REPEAT}},
        '{16'hAAAA,  1'b0, NO_RESULT},
        '{16'h5555,  1'b0, NO_RESULT},
        '{16'd3000,  1'b0, NO_RESULT},
        '{16'd1199,  1'b0, NO_RESULT},
        '{16'd1199,  1'b0, NO_RESULT},
        '{16'd1200,  1'b0, NO_RESULT}
    };

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void finish_frame(output t_frame_result r, input logic [7:0] addr,
                                         input logic [7:0] cmd, input t_status st);
        r = '{addr, cmd, st};
        dec_phase = PH_SKIP_LEAD;
    endfunction

    // advances the decoder model by one interval, returns 1 when a frame result comes out
    function automatic bit decode_interval(input logic [INTERVAL_W-1:0] t,
                                           output t_frame_result r);
        r = NO_RESULT;
        case (dec_phase)
            PH_LEADER: begin
                if (t < thr_leader) begin
                    finish_frame(r, 8'd0, 8'd0, ST_SHORT);
                    return 1'b1;
                end
                dec_phase = PH_SPACE;
            end
            PH_SPACE: begin
                if (t < thr_space) begin
                    dec_phase = PH_STOP_REPEAT;
                end else begin
                    dec_bit_cnt = '0;
                    dec_bits    = '0;
                    dec_phase   = PH_BIT_SKIP;
                end
            end
            PH_BIT_SKIP: dec_phase = PH_BIT_READ;
            PH_BIT_READ: begin
                if (t >= thr_one) dec_bits[dec_bit_cnt[4:0]] = 1'b1;
                dec_bit_cnt = dec_bit_cnt + 6'd1;
                dec_phase = (dec_bit_cnt >= 6'd32) ? PH_STOP_FRAME : PH_BIT_SKIP;
            end
            PH_STOP_REPEAT: begin
                finish_frame(r, 8'd0, 8'd0, ST_REPEAT);
                return 1'b1;
            end
            PH_STOP_FRAME: begin
                if (dec_bits[7:0] != ~dec_bits[15:8] || dec_bits[23:16] != ~dec_bits[31:24])
                    finish_frame(r, 8'd0, 8'hFF, ST_BADCHK);
                else
                    finish_frame(r, dec_bits[7:0], dec_bits[23:16], ST_OK);
                return 1'b1;
            end
            default: dec_phase = PH_LEADER;
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input t_frame_result want,
                                   input t_frame_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s: want addr %02h cmd %02h status %0d,", $realtime, what,
                     want.address, want.command, want.status,
                     " got addr %02h cmd %02h status %0d",
                     got.address, got.command, got.status);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.address, out_ch.command, t_status'(out_ch.status)};
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected item", NO_RESULT, got);
            end else begin
                want = expected_frames.pop_front();
                if (got.address != want.address || got.command != want.command ||
                    got.status != want.status)
                    report_mismatch("mismatch", want, got);
            end
        end
    end

    // receiver stalls
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(100, 1) <= ready_pct);
        end
    end

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            if (gap_max > 0) begin
                gap = $urandom_range(gap_max, 0);
                if (gap > 0) begin
                    @(negedge i_clk);
                    in_ch.valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
        burst_left--;
    endtask

    task automatic send_item(input logic [INTERVAL_W-1:0] v, input bit typed_en,
                             input t_frame_result typed);
        t_frame_result r;
        bit has_result;
        pace_sender();
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.interval_us <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        has_result = decode_interval(v, r);
        if (typed_en)
            expected_frames.push_back(typed);
        else if (has_result)
            expected_frames.push_back(r);
        items_sent++;
    endtask

    task automatic send_random();
        send_item(16'($urandom_range(65535, 0)), 1'b0, NO_RESULT);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_LEADER_MIN: thr_leader = val;
            CFG_SPACE_MIN:  thr_space  = val;
            CFG_ONE_MIN:    thr_one    = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [INTERVAL_W-1:0] pick_at_least(input logic [CFG_DATA_W-1:0] lo);
        return 16'($urandom_range(65535, lo));
    endfunction

    function automatic logic [INTERVAL_W-1:0] pick_below(input logic [CFG_DATA_W-1:0] hi);
        if (hi == 0) return 16'($urandom_range(65535, 0));
        return 16'($urandom_range(hi - 1, 0));
    endfunction

    // builds a frame into seq_buf; about a quarter of frames get a random data word
    task automatic build_frame();
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [FRAME_BITS-1:0] word;
        addr = 8'($urandom);
        cmd  = 8'($urandom);
        word = {~cmd, cmd, ~addr, addr};
        if ($urandom_range(99, 0) < 25) word = $urandom;
        seq_buf.push_back(16'($urandom_range(65535, 0)));
        seq_buf.push_back(pick_at_least(thr_leader));
        seq_buf.push_back(pick_at_least(thr_space));
        for (int b = 0; b < FRAME_BITS; b++) begin
            seq_buf.push_back(16'($urandom_range(65535, 0)));
            seq_buf.push_back(word[b] ? pick_at_least(thr_one) : pick_below(thr_one));
        end
        seq_buf.push_back(16'($urandom_range(65535, 0)));
    endtask

    task automatic send_sequence();
        int kind;
        int n;
        while (dec_phase != PH_SKIP_LEAD) send_random();
        seq_buf.delete();
        kind = $urandom_range(99, 0);
        if (kind < 70 && kind >= 55 && thr_space != 0) begin
            seq_buf.push_back(16'($urandom_range(65535, 0)));
            seq_buf.push_back(pick_at_least(thr_leader));
            seq_buf.push_back(pick_below(thr_space));
            seq_buf.push_back(16'($urandom_range(65535, 0)));
        end else if (kind < 82 && kind >= 70 && thr_leader != 0) begin
            seq_buf.push_back(16'($urandom_range(65535, 0)));
            seq_buf.push_back(pick_below(thr_leader));
        end else if (kind < 92 && kind >= 82) begin
            n = $urandom_range(10, 1);
            repeat (n) seq_buf.push_back(16'($urandom_range(65535, 0)));
        end else begin
            build_frame();
            // broken frame: cut short somewhere
            if (kind >= 92) seq_buf = seq_buf[0:$urandom_range(seq_buf.size() - 2, 1)];
        end
        foreach (seq_buf[k]) send_item(seq_buf[k], 1'b0, NO_RESULT);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] leader_set [NUM_PHASES];
        logic [CFG_DATA_W-1:0] space_set  [NUM_PHASES];
        logic [CFG_DATA_W-1:0] one_set    [NUM_PHASES];
        int ready_set [NUM_PHASES];
        int gap_set   [NUM_PHASES];
        int phase_start;

        leader_set = '{16'd7500, 16'd0, 16'd65535, 16'd0, 16'd9000};
        space_set  = '{16'd3000, 16'd0, 16'd65535, 16'd0, 16'd4500};
        one_set    = '{16'd1200, 16'd0, 16'd65535, 16'd0, 16'd1690};
        ready_set  = '{100, 60, 25, 85, 50};
        gap_set    = '{0, 4, 2, 8, 0};

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_wdata       = '0;
        in_ch.valid       = 1'b0;
        in_ch.interval_us = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        ready_pct = 70;
        gap_max   = 3;
        foreach (directed_rows[r])
            send_item(directed_rows[r].interval, directed_rows[r].typed_en,
                      directed_rows[r].typed);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 3) begin
                leader_set[p] = 16'($urandom);
                space_set[p]  = 16'($urandom);
                one_set[p]    = 16'($urandom);
            end
            if (p > 0) begin
                write_reg(CFG_LEADER_MIN, leader_set[p]);
                write_reg(CFG_SPACE_MIN, space_set[p]);
                write_reg(CFG_ONE_MIN, one_set[p]);
                if (p == 1) write_reg(CFG_IDX_UNUSED, 16'($urandom));
                end_writes();
            end
            ready_pct = ready_set[p];
            gap_max   = gap_set[p];
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_sequence();
            drain();
        end

        foreach (expected_frames[k]) report_mismatch("missing item", expected_frames[k], NO_RESULT);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
